### rtl/ccc_pkg.sv
// Shared types, constants and calendar helpers for the calendar clock counter.
// Used by ccc_step and calendar_clock_counter_core; depends on nothing else.
`default_nettype none

package ccc_pkg;

  // Field widths
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned Hour12W = 4;

  // Counter limits
  localparam logic [SecondW-1:0] SecondLast = SecondW'(59);
  localparam logic [MinuteW-1:0] MinuteLast = MinuteW'(59);
  localparam logic [HourW-1:0]   HourLast   = HourW'(23);
  localparam logic [HourW-1:0]   HourNoon   = HourW'(12);
  localparam logic [MonthW-1:0]  MonthFirst = MonthW'(1);
  localparam logic [MonthW-1:0]  MonthLast  = MonthW'(12);
  localparam logic [DayW-1:0]    DayFirst   = DayW'(1);
  localparam logic [YearW-1:0]   YearLast   = YearW'(9999);

  // Month codes with short lengths
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonthJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonthSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonthNov = MonthW'(11);

  // Reset date: first of January 2021, midnight
  localparam logic [YearW-1:0] YearReset = YearW'(2021);

  // Divisibility by 25 through the multiplicative inverse of 25 modulo 2^14:
  // y is a multiple of 25 exactly when (y * inv) mod 2^14 <= (2^14 - 1) / 25.
  localparam logic [YearW-1:0] Inv25     = YearW'(7209);
  localparam logic [YearW-1:0] Div25Max  = YearW'(((1 << YearW) - 1) / 25);

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } time_t;

  function automatic logic is_div25(input logic [YearW-1:0] y);
    logic [2*YearW-1:0] prod;
    prod = (2*YearW)'(y) * (2*YearW)'(Inv25);
    return prod[YearW-1:0] <= Div25Max;
  endfunction

  // Gregorian leap year: divisible by 4, and either not by 25 or also by 16
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic div25;
    div25 = is_div25(y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [YearW-1:0] y,
                                                input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    len = DayW'(31);
    if (m == MonthFeb) begin
      len = is_leap(y) ? DayW'(29) : DayW'(28);
    end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      len = DayW'(30);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/ccc_step.sv
// Next-state logic for one beat: a one-second tick with full calendar carry,
// or a checked load of a new date and time. Depends on ccc_pkg.
`default_nettype none

module ccc_step (
  input  wire logic                          mode_i,
  input  wire ccc_pkg::time_t                state_i,
  input  wire ccc_pkg::time_t                set_i,
  output      ccc_pkg::time_t                state_o,
  output      logic                          rejected_o,
  output      logic [ccc_pkg::Hour12W-1:0]   hour_twelve_o,
  output      logic                          is_pm_o
);

  ccc_pkg::time_t tick_state;
  logic           sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
  logic           set_ok;

  // Tick: cascade of wrap conditions
  always_comb begin
    sec_wrap   = (state_i.second == ccc_pkg::SecondLast);
    min_wrap   = sec_wrap  && (state_i.minute == ccc_pkg::MinuteLast);
    hour_wrap  = min_wrap  && (state_i.hour   == ccc_pkg::HourLast);
    day_wrap   = hour_wrap &&
                 (state_i.day >= ccc_pkg::month_len(state_i.year, state_i.month));
    month_wrap = day_wrap  && (state_i.month >= ccc_pkg::MonthLast);

    tick_state        = state_i;
    tick_state.second = sec_wrap ? '0 : state_i.second + 1'b1;
    if (sec_wrap) begin
      tick_state.minute = min_wrap ? '0 : state_i.minute + 1'b1;
    end
    if (min_wrap) begin
      tick_state.hour = hour_wrap ? '0 : state_i.hour + 1'b1;
    end
    if (hour_wrap) begin
      tick_state.day = day_wrap ? ccc_pkg::DayFirst : state_i.day + 1'b1;
    end
    if (day_wrap) begin
      tick_state.month = month_wrap ? ccc_pkg::MonthFirst : state_i.month + 1'b1;
    end
    if (month_wrap) begin
      tick_state.year = (state_i.year >= ccc_pkg::YearLast) ? '0 : state_i.year + 1'b1;
    end
  end

  // Set request check, day against the requested month and year
  assign set_ok = (set_i.year <= ccc_pkg::YearLast) &&
                  (set_i.month >= ccc_pkg::MonthFirst) &&
                  (set_i.month <= ccc_pkg::MonthLast) &&
                  (set_i.day >= ccc_pkg::DayFirst) &&
                  (set_i.hour <= ccc_pkg::HourLast) &&
                  (set_i.minute <= ccc_pkg::MinuteLast) &&
                  (set_i.second <= ccc_pkg::SecondLast) &&
                  (set_i.day <= ccc_pkg::month_len(set_i.year, set_i.month));

  // Select next state and the 12-hour view
  always_comb begin
    rejected_o = 1'b0;
    if (!mode_i) begin
      state_o = tick_state;
    end else if (set_ok) begin
      state_o = set_i;
    end else begin
      state_o    = state_i;
      rejected_o = 1'b1;
    end
    is_pm_o       = (state_o.hour >= ccc_pkg::HourNoon);
    hour_twelve_o = is_pm_o ? ccc_pkg::Hour12W'(state_o.hour - ccc_pkg::HourNoon)
                            : ccc_pkg::Hour12W'(state_o.hour);
  end

endmodule

`default_nettype wire

### rtl/calendar_clock_counter_core.sv
// Real-time clock and calendar core: input register, calendar step, result
// register. Depends on ccc_pkg and ccc_step.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one beat per item: mode_i
//   low advances the clock by one second, mode_i high asks to load the set_*
//   fields. A bad set request (field out of range, or a day past the end of
//   that month in that year) leaves the time as it was and raises
//   set_rejected_o in its result.
//   Output channel (out_valid_o / out_stall_i) returns one beat per item with
//   the full date and time after that item, the 12-hour hour and the PM flag.
//   An accepted item passes the input register, then the calendar step, which
//   feeds the result register, where its result becomes valid.
//   Throughput is one item per cycle while the receiver does not stall; the
//   calendar state is updated in the cycle the item moves into the result
//   register, so back-to-back items see each other's effect with no gap.
//   When the receiver stalls, the result is held and the input register keeps
//   one more item; in_stall_o is raised only once both registers are full.
//   Reset clears both registers and sets the clock to 2021-01-01 00:00:00.
`default_nettype none

module calendar_clock_counter_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [ccc_pkg::YearW-1:0]     set_year_i,
  input  wire logic [ccc_pkg::MonthW-1:0]    set_month_i,
  input  wire logic [ccc_pkg::DayW-1:0]      set_day_i,
  input  wire logic [ccc_pkg::HourW-1:0]     set_hour_i,
  input  wire logic [ccc_pkg::MinuteW-1:0]   set_minute_i,
  input  wire logic [ccc_pkg::SecondW-1:0]   set_second_i,
  // Output channel
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [ccc_pkg::YearW-1:0]     cur_year_o,
  output      logic [ccc_pkg::MonthW-1:0]    cur_month_o,
  output      logic [ccc_pkg::DayW-1:0]      cur_day_o,
  output      logic [ccc_pkg::HourW-1:0]     cur_hour_o,
  output      logic [ccc_pkg::MinuteW-1:0]   cur_minute_o,
  output      logic [ccc_pkg::SecondW-1:0]   cur_second_o,
  output      logic [ccc_pkg::Hour12W-1:0]   hour_twelve_o,
  output      logic                          is_pm_o,
  output      logic                          set_rejected_o
);

  logic                        in_vld_q;
  logic                        mode_q;
  ccc_pkg::time_t              set_q;
  logic                        res_vld_q;
  ccc_pkg::time_t              res_time_q;
  logic [ccc_pkg::Hour12W-1:0] res_h12_q;
  logic                        res_pm_q;
  logic                        res_rej_q;
  ccc_pkg::time_t              state_q, state_d;
  logic                        step_rej;
  logic [ccc_pkg::Hour12W-1:0] step_h12;
  logic                        step_pm;
  logic                        res_ready, in_ready, ld_res;

  // Handshake: result slot frees when empty or taken; input slot when it moves on
  assign res_ready  = !res_vld_q || !out_stall_i;
  assign ld_res     = in_vld_q && res_ready;
  assign in_ready   = !in_vld_q || res_ready;
  assign in_stall_o = !in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      mode_q <= mode_i;
      set_q  <= '{year: set_year_i, month: set_month_i, day: set_day_i,
                  hour: set_hour_i, minute: set_minute_i, second: set_second_i};
    end
  end

  // Calendar step
  ccc_step u_step (
    .mode_i        (mode_q),
    .state_i       (state_q),
    .set_i         (set_q),
    .state_o       (state_d),
    .rejected_o    (step_rej),
    .hour_twelve_o (step_h12),
    .is_pm_o       (step_pm)
  );

  // Clock and calendar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{year: ccc_pkg::YearReset, month: ccc_pkg::MonthFirst,
                   day: ccc_pkg::DayFirst, hour: '0, minute: '0, second: '0};
    end else if (ld_res) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_ready) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_res) begin
      res_time_q <= state_d;
      res_h12_q  <= step_h12;
      res_pm_q   <= step_pm;
      res_rej_q  <= step_rej;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign cur_year_o     = res_time_q.year;
  assign cur_month_o    = res_time_q.month;
  assign cur_day_o      = res_time_q.day;
  assign cur_hour_o     = res_time_q.hour;
  assign cur_minute_o   = res_time_q.minute;
  assign cur_second_o   = res_time_q.second;
  assign hour_twelve_o  = res_h12_q;
  assign is_pm_o        = res_pm_q;
  assign set_rejected_o = res_rej_q;

  // Checks
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.second <= ccc_pkg::SecondLast) && (state_q.minute <= ccc_pkg::MinuteLast) &&
    (state_q.hour <= ccc_pkg::HourLast) && (state_q.month >= ccc_pkg::MonthFirst) &&
    (state_q.month <= ccc_pkg::MonthLast) && (state_q.year <= ccc_pkg::YearLast))
    else $error("calendar state out of range");

  a_day_fits_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.day >= ccc_pkg::DayFirst) &&
    (state_q.day <= ccc_pkg::month_len(state_q.year, state_q.month)))
    else $error("day beyond month length");

  a_pm_matches_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_pm_o == (cur_hour_o >= ccc_pkg::HourNoon)))
    else $error("PM flag disagrees with hour");

  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_res && step_rej |=> (state_q == $past(state_q)))
    else $error("rejected set changed the state");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_res |=> (res_time_q == state_q))
    else $error("result does not show the updated state");

endmodule

`default_nettype wire
